>>> rtl/cifir_pkg.sv
// ----------------------------------------------------------------------------
// cifir_pkg
// Shared types and constants for the complex Q15 direct-form-I IIR filter:
// transaction payloads, complex sample type, command codes and MAC control.
// ----------------------------------------------------------------------------
package cifir_pkg;

    // Default tap counts
    localparam int FF_TAPS_DEF = 8;
    localparam int FB_TAPS_DEF = 8;

    // Q15 fraction bits
    localparam int FRAC_BITS = 15;
    localparam int ACC_W     = 32;

    // Command codes
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    // Coefficient store select
    localparam logic SIDE_FF = 1'b0;
    localparam logic SIDE_FB = 1'b1;

    // Complex Q15 value
    typedef struct packed {
        logic signed [15:0] re;
        logic signed [15:0] im;
    } cplx_t;

    // Request transaction payload
    typedef struct packed {
        logic               command;
        logic               first_of_block;
        logic signed [15:0] sample_re;
        logic signed [15:0] sample_im;
        logic               coef_side;
        logic [2:0]         coef_index;
        logic signed [15:0] coef_re;
        logic signed [15:0] coef_im;
    } req_item_t;

    // Response transaction payload
    typedef struct packed {
        logic signed [15:0] out_re;
        logic signed [15:0] out_im;
    } rsp_item_t;

    // Per-tap control for the MAC unit
    typedef struct packed {
        logic vld;    // a tap product is presented
        logic fb;     // feedback side: subtract
        logic first;  // first tap of its side
        logic last;   // last tap of the sample
    } mac_ctl_t;

endpackage

>>> rtl/complex_fixed_iir_filter.sv
// ----------------------------------------------------------------------------
// complex_fixed_iir_filter
// Direct-form-I IIR filter on complex Q15 samples with loadable complex
// coefficients. Coefficients and histories live in two synchronous memories
// walked one tap per cycle through a shared complex MAC.
// ----------------------------------------------------------------------------
//  Channel | Ports                      | Payload
//  --------+----------------------------+------------------------------------
//  request | req_valid, req_stall, req  | command, sample, coefficient write
//  result  | rsp_valid, rsp_stall, rsp  | filtered sample (filter cmd only)
//
//  A coefficient write leaves the block idle for the next request. A filter
//  transaction holds req_stall until its walk ends; the single MAC reads one
//  tap per cycle from the memory read port. Reset clears all stores through
//  per-entry valid bits.
//  A result waits in the output register under stall while the next
//  transaction is accepted; the walk holds at its end until that register
//  is free.
// ----------------------------------------------------------------------------
module complex_fixed_iir_filter
    import cifir_pkg::*;
#(
    parameter int FF_TAPS = FF_TAPS_DEF,
    parameter int FB_TAPS = FB_TAPS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    // Both sides share one address space: feed-forward first, then feedback
    localparam int DEPTH = FF_TAPS + FB_TAPS;
    localparam int AW    = $clog2(DEPTH);
    localparam int N_MAC = DEPTH - 1;

    localparam logic [AW-1:0] CNT_LAST = AW'(N_MAC - 1);
    localparam logic [AW-1:0] FB_START = AW'(FF_TAPS);
    localparam logic [AW-1:0] Y1_ADDR  = AW'(FF_TAPS + 1);

    // State codes
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ISSUE  = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [AW-1:0]    cnt_reg, cnt_next;
    cplx_t            cur_reg;
    cplx_t            held_reg;

    // Memories and their valid bits
    cplx_t            coef_mem [DEPTH];
    cplx_t            hist_mem [DEPTH];
    logic [DEPTH-1:0] coef_vld_reg;
    logic [DEPTH-1:0] hist_vld_reg;
    cplx_t            coef_rd_reg, hist_rd_reg;
    logic             coef_rv_reg, hist_rv_reg;

    // Issue stage
    logic             req_acc;
    logic             iss_vld, iss_fb;
    logic [AW-1:0]    iss_addr;
    mac_ctl_t         iss_ctl;
    logic             iss_wr, iss_cur;

    // Data stage (aligned with memory read data)
    mac_ctl_t         ctl1_reg;
    logic             wr1_reg, cur1_reg;
    logic [AW-1:0]    addr1_reg;

    // Write ports
    logic             coef_we;
    logic [AW-1:0]    coef_waddr;
    cplx_t            coef_wdata;
    logic             hist_we;
    logic [AW-1:0]    hist_waddr;
    cplx_t            hist_wdata;

    // MAC operands and result
    cplx_t            hist_a, op_a, op_b;
    logic [ACC_W-1:0] acc_re, acc_im;
    logic             mac_done;
    rsp_item_t        res;
    logic             out_space, finish_go;
    logic             out_valid_reg;
    rsp_item_t        out_reg;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_acc   = req_valid && !req_stall;

    // Coefficient write decode; out-of-range index is dropped
    always_comb
    begin
        coef_we    = 1'b0;
        coef_waddr = '0;
        coef_wdata = '{re: req.coef_re, im: req.coef_im};
        if (req_acc && req.command == CMD_COEF)
        begin
            if (req.coef_side == SIDE_FF)
            begin
                coef_we    = ({29'd0, req.coef_index} < FF_TAPS);
                coef_waddr = AW'({29'd0, req.coef_index});
            end
            else
            begin
                coef_we    = ({29'd0, req.coef_index} < FB_TAPS);
                coef_waddr = AW'(FF_TAPS + {29'd0, req.coef_index});
            end
        end
    end

    // Tap walk: feed-forward taps 0..FF-1, then feedback taps 1..FB-1
    assign iss_vld  = (state_reg == ST_ISSUE);
    assign iss_fb   = (cnt_reg >= FB_START);
    assign iss_addr = iss_fb ? (cnt_reg + 1'b1) : cnt_reg;
    assign iss_cur  = (cnt_reg == '0);
    assign iss_wr   = !(cnt_reg == '0) && !(cnt_reg == FB_START);
    assign iss_ctl  = '{vld:   iss_vld,
                        fb:    iss_fb,
                        first: (cnt_reg == '0) || (cnt_reg == FB_START),
                        last:  (cnt_reg == CNT_LAST)};

    // Finish: write y[1] and load the output register together
    assign out_space = !out_valid_reg || !rsp_stall;
    assign finish_go = (state_reg == ST_FINISH) && out_space;
    assign res       = '{out_re: acc_re[FRAC_BITS+15:FRAC_BITS],
                         out_im: acc_im[FRAC_BITS+15:FRAC_BITS]};

    // History write: shift during the walk, newest output at the end
    always_comb
    begin
        hist_we    = 1'b0;
        hist_waddr = addr1_reg;
        hist_wdata = held_reg;
        if (finish_go)
        begin
            hist_we    = 1'b1;
            hist_waddr = Y1_ADDR;
            hist_wdata = '{re: res.out_re, im: res.out_im};
        end
        else if (ctl1_reg.vld && wr1_reg)
        begin
            hist_we = 1'b1;
        end
    end

    // Memories
    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        coef_rd_reg <= coef_mem[iss_addr];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_rd_reg <= hist_mem[iss_addr];
    end

    // Valid bits: unwritten or cleared entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg <= '0;
            hist_vld_reg <= '0;
            coef_rv_reg  <= 1'b0;
            hist_rv_reg  <= 1'b0;
        end
        else
        begin
            if (coef_we)
            begin
                coef_vld_reg[coef_waddr] <= 1'b1;
            end
            if (req_acc && req.command == CMD_FILTER && req.first_of_block)
            begin
                hist_vld_reg <= '0;
            end
            else if (hist_we)
            begin
                hist_vld_reg[hist_waddr] <= 1'b1;
            end
            coef_rv_reg <= coef_vld_reg[iss_addr];
            hist_rv_reg <= hist_vld_reg[iss_addr];
        end
    end

    // Operand select
    assign hist_a = hist_rv_reg ? hist_rd_reg : '0;
    assign op_a   = cur1_reg ? cur_reg : hist_a;
    assign op_b   = coef_rv_reg ? coef_rd_reg : '0;

    // Data stage payload
    always_ff @(posedge clk)
    begin
        wr1_reg   <= iss_wr;
        cur1_reg  <= iss_cur;
        addr1_reg <= iss_addr;
        if (req_acc && req.command == CMD_FILTER)
        begin
            cur_reg <= '{re: req.sample_re, im: req.sample_im};
        end
        if (ctl1_reg.vld)
        begin
            held_reg <= op_a;
        end
        if (finish_go)
        begin
            out_reg <= res;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (req_acc && req.command == CMD_FILTER)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (mac_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_space)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ctl1_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ctl1_reg  <= iss_ctl;
            if (finish_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Shared complex MAC
    cifir_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl1_reg),
        .a      (op_a),
        .b      (op_b),
        .acc_re (acc_re),
        .acc_im (acc_im),
        .done   (mac_done)
    );

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

>>> rtl/cifir_mac.sv
// ----------------------------------------------------------------------------
// cifir_mac
// Shared complex multiply-accumulate. One tap per cycle: four 16x16 products
// are registered, then combined and added into (feed-forward) or subtracted
// from (feedback) a 32-bit wrapping accumulator pair.
// ----------------------------------------------------------------------------
module cifir_mac
    import cifir_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  mac_ctl_t         ctl,
    input  cplx_t            a,
    input  cplx_t            b,
    output logic [ACC_W-1:0] acc_re,
    output logic [ACC_W-1:0] acc_im,
    output logic             done
);

    mac_ctl_t                ctl_reg;
    logic signed [ACC_W-1:0] rr_reg, ii_reg, ri_reg, ir_reg;
    logic [ACC_W-1:0]        acc_re_reg, acc_im_reg;
    logic [ACC_W-1:0]        acc_re_next, acc_im_next;
    logic [ACC_W-1:0]        prod_re, prod_im;
    logic [ACC_W-1:0]        base_re, base_im;
    logic                    done_reg;

    // Product stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_reg  <= ctl;
            done_reg <= ctl_reg.vld && ctl_reg.last;
        end
    end

    // Partial products, exact in 32 bits
    always_ff @(posedge clk)
    begin
        rr_reg <= a.re * b.re;
        ii_reg <= a.im * b.im;
        ri_reg <= a.re * b.im;
        ir_reg <= a.im * b.re;
    end

    // Combine products, wrapping at 32 bits
    assign prod_re = ACC_W'(rr_reg) - ACC_W'(ii_reg);
    assign prod_im = ACC_W'(ri_reg) + ACC_W'(ir_reg);

    // First feedback tap: drop the fraction of the feed-forward sum
    assign base_re = {acc_re_reg[ACC_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
    assign base_im = {acc_im_reg[ACC_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};

    // Accumulate
    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        if (ctl_reg.vld)
        begin
            if (!ctl_reg.fb && ctl_reg.first)
            begin
                acc_re_next = prod_re;
                acc_im_next = prod_im;
            end
            else if (!ctl_reg.fb)
            begin
                acc_re_next = acc_re_reg + prod_re;
                acc_im_next = acc_im_reg + prod_im;
            end
            else if (ctl_reg.first)
            begin
                acc_re_next = base_re - prod_re;
                acc_im_next = base_im - prod_im;
            end
            else
            begin
                acc_re_next = acc_re_reg - prod_re;
                acc_im_next = acc_im_reg - prod_im;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_re_reg <= acc_re_next;
        acc_im_reg <= acc_im_next;
    end

    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;
    assign done   = done_reg;

endmodule

>>> test/complex_fixed_iir_filter_tb.sv
// ----------------------------------------------------------------------------
// complex_fixed_iir_filter_tb
// Self-checking bench for the complex Q15 direct-form-I IIR filter. A driver
// feeds request transactions from a queue and mirrors each accepted one into
// a bit-exact software filter. A monitor compares every result transaction
// with the oldest predicted output. Both sides idle at random, apart from
// one stretch of back-to-back traffic.
// ----------------------------------------------------------------------------
module complex_fixed_iir_filter_tb;
    import cifir_pkg::*;

    localparam int FF_TAPS     = FF_TAPS_DEF;
    localparam int FB_TAPS     = FB_TAPS_DEF;
    localparam int IDLE_PCT    = 34;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = FF_TAPS + FB_TAPS + 24;
    localparam int QUIET_START = 4000;
    localparam int QUIET_END   = 9000;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } acc_pair_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp;

    // Software copy of the filter state
    cplx_t ff_coefs [FF_TAPS];
    cplx_t fb_coefs [FB_TAPS];
    cplx_t x_hist   [FF_TAPS];
    cplx_t y_hist   [FB_TAPS];

    req_item_t pending_reqs[$];
    rsp_item_t expected_outputs[$];
    int        error_count = 0;
    int        cycle_count = 0;
    logic      quiet;

    assign quiet = (cycle_count >= QUIET_START) && (cycle_count < QUIET_END);

    complex_fixed_iir_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Exact complex product, partial products in 32 bits, sums wrap
    function automatic acc_pair_t cplx_mul(cplx_t a, cplx_t b);
        logic signed [31:0] ar, ai, br, bi;
        acc_pair_t p;
        ar = $signed(a.re);
        ai = $signed(a.im);
        br = $signed(b.re);
        bi = $signed(b.im);
        p.re = ar * br - ai * bi;
        p.im = ar * bi + ai * br;
        return p;
    endfunction

    // One filter step: updates the histories and returns the output sample
    function automatic rsp_item_t filter_sample(req_item_t t);
        acc_pair_t acc, p;
        cplx_t cur;
        logic signed [31:0] q_re, q_im;
        rsp_item_t r;
        if (t.first_of_block)
        begin
            for (int i = 0; i < FF_TAPS; i++) x_hist[i] = '0;
            for (int i = 0; i < FB_TAPS; i++) y_hist[i] = '0;
        end
        cur.re = t.sample_re;
        cur.im = t.sample_im;
        acc = cplx_mul(cur, ff_coefs[0]);
        for (int i = 1; i < FF_TAPS; i++)
        begin
            p = cplx_mul(x_hist[i], ff_coefs[i]);
            acc.re = acc.re + p.re;
            acc.im = acc.im + p.im;
        end
        // requantize the feed-forward sum, then feedback at full precision
        acc.re = (acc.re >>> 15) <<< 15;
        acc.im = (acc.im >>> 15) <<< 15;
        for (int i = 1; i < FB_TAPS; i++)
        begin
            p = cplx_mul(fb_coefs[i], y_hist[i]);
            acc.re = acc.re - p.re;
            acc.im = acc.im - p.im;
        end
        q_re = acc.re >>> 15;
        q_im = acc.im >>> 15;
        r.out_re = q_re[15:0];
        r.out_im = q_im[15:0];
        for (int i = FF_TAPS - 1; i > 1; i--) x_hist[i] = x_hist[i - 1];
        for (int i = FB_TAPS - 1; i > 1; i--) y_hist[i] = y_hist[i - 1];
        x_hist[1] = cur;
        y_hist[1].re = r.out_re;
        y_hist[1].im = r.out_im;
        return r;
    endfunction

    // Mirror one accepted request transaction into the software filter
    function automatic void predict_transaction(req_item_t t);
        cplx_t c;
        if (t.command == CMD_COEF)
        begin
            c.re = t.coef_re;
            c.im = t.coef_im;
            if (t.coef_side == SIDE_FF)
            begin
                if (int'(t.coef_index) < FF_TAPS) ff_coefs[t.coef_index] = c;
            end
            else if (int'(t.coef_index) < FB_TAPS)
                fb_coefs[t.coef_index] = c;
        end
        else
            expected_outputs.push_back(filter_sample(t));
    endfunction

    function automatic req_item_t make_filter(logic first, logic [15:0] re, logic [15:0] im);
        req_item_t t;
        t = req_item_t'({$urandom, $urandom, $urandom});
        t.command        = CMD_FILTER;
        t.first_of_block = first;
        t.sample_re      = re;
        t.sample_im      = im;
        return t;
    endfunction

    function automatic req_item_t make_coef(logic side, logic [2:0] idx,
                                            logic [15:0] re, logic [15:0] im);
        req_item_t t;
        t = req_item_t'({$urandom, $urandom, $urandom});
        t.command    = CMD_COEF;
        t.coef_side  = side;
        t.coef_index = idx;
        t.coef_re    = re;
        t.coef_im    = im;
        return t;
    endfunction

    // Full-range or scaled-down coefficient value
    function automatic logic [15:0] rand_coef();
        logic signed [15:0] v;
        v = 16'($urandom);
        if ($urandom_range(1, 0) != 0)
            v = v >>> $urandom_range(7, 1);
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("MISMATCH cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        error_count++;
    endtask

    // Request driver: new transaction only when the slot is free
    always @(posedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else
        begin
            if (req_valid && !req_stall)
                predict_transaction(req);
            if (!req_valid || !req_stall)
            begin
                if (pending_reqs.size() > 0 && (quiet || $urandom_range(99, 0) >= IDLE_PCT))
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Result monitor and random stall
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_outputs.size() == 0)
                begin
                    $display("MISMATCH cycle %0d: result with none expected", cycle_count);
                    error_count++;
                end
                else
                begin
                    if (rsp.out_re !== expected_outputs[0].out_re)
                        report_mismatch("out_re", rsp.out_re, expected_outputs[0].out_re);
                    if (rsp.out_im !== expected_outputs[0].out_im)
                        report_mismatch("out_im", rsp.out_im, expected_outputs[0].out_im);
                    void'(expected_outputs.pop_front());
                end
            end
            rsp_stall <= !quiet && ($urandom_range(99, 0) < IDLE_PCT);
        end
    end

    // Cycle count and timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("complex_fixed_iir_filter test failed");
            $finish;
        end
    end

    initial
    begin
        int block_len;
        int n_writes;
        logic first;

        for (int i = 0; i < FF_TAPS; i++) begin ff_coefs[i] = '0; x_hist[i] = '0; end
        for (int i = 0; i < FB_TAPS; i++) begin fb_coefs[i] = '0; y_hist[i] = '0; end

        // Directed: zero coefficients, extremes, unused feedback tap, block restart
        pending_reqs.push_back(make_filter(1'b0, 16'h7fff, 16'h8000));
        pending_reqs.push_back(make_coef(SIDE_FF, 3'd0, 16'h7fff, 16'h0000));
        pending_reqs.push_back(make_filter(1'b1, 16'h7fff, 16'h8000));
        pending_reqs.push_back(make_filter(1'b0, 16'h8000, 16'h7fff));
        pending_reqs.push_back(make_coef(SIDE_FF, 3'd1, 16'h8000, 16'h8000));
        pending_reqs.push_back(make_coef(SIDE_FB, 3'd1, 16'h4000, 16'h0000));
        pending_reqs.push_back(make_coef(SIDE_FB, 3'd0, 16'h7fff, 16'h7fff));
        pending_reqs.push_back(make_filter(1'b0, 16'h8000, 16'h8000));
        pending_reqs.push_back(make_filter(1'b0, 16'h7fff, 16'h7fff));
        pending_reqs.push_back(make_coef(SIDE_FF, 3'd7, 16'h7fff, 16'h8000));
        pending_reqs.push_back(make_coef(SIDE_FB, 3'd7, 16'h8000, 16'h7fff));
        pending_reqs.push_back(make_coef(SIDE_FF, 3'd0, 16'h8000, 16'h8000));
        for (int k = 0; k < 8; k++)
            pending_reqs.push_back(make_filter(1'b0, (k % 2) ? 16'h8000 : 16'h7fff,
                                               (k % 3) ? 16'h7fff : 16'h8000));
        pending_reqs.push_back(make_filter(1'b1, 16'h0000, 16'h0000));
        pending_reqs.push_back(make_filter(1'b0, 16'h0001, 16'hffff));
        pending_reqs.push_back(make_filter(1'b1, 16'hffff, 16'h0001));

        // Random: coefficient reloads followed by blocks of samples
        while (pending_reqs.size() < 920)
        begin
            n_writes = $urandom_range(4, 0);
            for (int k = 0; k < n_writes; k++)
                pending_reqs.push_back(make_coef(1'($urandom), 3'($urandom),
                                                 rand_coef(), rand_coef()));
            block_len = $urandom_range(40, 4);
            for (int k = 0; k < block_len; k++)
            begin
                if (k == 0)
                    first = ($urandom_range(9, 0) != 0);
                else
                    first = ($urandom_range(49, 0) == 0);
                pending_reqs.push_back(make_filter(first, 16'($urandom), 16'($urandom)));
                if ($urandom_range(29, 0) == 0)
                    pending_reqs.push_back(make_coef(1'($urandom), 3'($urandom),
                                                     rand_coef(), rand_coef()));
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Poll between edges so driver and monitor updates have settled
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || req_valid || expected_outputs.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_outputs.size() != 0)
        begin
            $display("MISMATCH: %0d results never arrived", expected_outputs.size());
            error_count++;
        end

        if (error_count == 0)
            $display("complex_fixed_iir_filter test passed");
        else
            $display("complex_fixed_iir_filter test failed");
        $finish;
    end

endmodule

>>> files.f
rtl/cifir_pkg.sv
rtl/cifir_mac.sv
rtl/complex_fixed_iir_filter.sv
test/complex_fixed_iir_filter_tb.sv
